@@ sv/sdes_pkg.sv @@
`timescale 1ns / 1ps
// sdes_pkg: widths, permutation tables, s-boxes and round helper functions
// for the simplified des cipher; no dependencies

package sdes_pkg;

   localparam int KeyWidth   = 10;
   localparam int BlockWidth = 8;
   localparam int HalfWidth  = 4;
   localparam int SubkeyWidth = 8;

   typedef logic [KeyWidth-1:0]    key_type;
   typedef logic [BlockWidth-1:0]  block_type;
   typedef logic [HalfWidth-1:0]   half_type;
   typedef logic [SubkeyWidth-1:0] subkey_type;
   typedef logic [1:0]             sbox_out_type;

   typedef logic [3:0] idx_type;

   localparam idx_type TabP10 [10] = '{4'd9, 4'd7, 4'd3, 4'd8, 4'd0,
                                        4'd2, 4'd6, 4'd5, 4'd1, 4'd4};
   localparam idx_type TabP8 [8]   = '{4'd3, 4'd1, 4'd7, 4'd5, 4'd0, 4'd6, 4'd4, 4'd2};
   localparam idx_type TabIp [8]   = '{4'd7, 4'd6, 4'd4, 4'd0, 4'd2, 4'd5, 4'd1, 4'd3};
   localparam idx_type TabIpInv [8] = '{4'd3, 4'd6, 4'd4, 4'd7, 4'd2, 4'd5, 4'd1, 4'd0};
   localparam idx_type TabE [8]    = '{4'd0, 4'd1, 4'd0, 4'd0, 4'd2, 4'd3, 4'd3, 4'd2};
   localparam idx_type TabP4 [4]   = '{4'd1, 4'd0, 4'd3, 4'd2};

   localparam sbox_out_type TabS0 [16] = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd3, 2'd1, 2'd0, 2'd2,
                                           2'd2, 2'd0, 2'd3, 2'd1, 2'd1, 2'd3, 2'd2, 2'd0};
   localparam sbox_out_type TabS1 [16] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1,
                                           2'd1, 2'd0, 2'd3, 2'd2, 2'd2, 2'd1, 2'd3, 2'd0};

   // msb-first: output position j takes input position tab[j]
   function automatic key_type perm_p10(key_type v);
      key_type r;
      r = '0;
      for (int j = 0; j < KeyWidth; j++) begin
         r[KeyWidth-1-j] = v[KeyWidth-1-int'(TabP10[j])];
      end
      return r;
   endfunction

   function automatic subkey_type perm_p8(subkey_type v);
      subkey_type r;
      r = '0;
      for (int j = 0; j < SubkeyWidth; j++) begin
         r[SubkeyWidth-1-j] = v[SubkeyWidth-1-int'(TabP8[j])];
      end
      return r;
   endfunction

   function automatic block_type perm_ip(block_type v);
      block_type r;
      r = '0;
      for (int j = 0; j < BlockWidth; j++) begin
         r[BlockWidth-1-j] = v[BlockWidth-1-int'(TabIp[j])];
      end
      return r;
   endfunction

   function automatic block_type perm_ip_inv(block_type v);
      block_type r;
      r = '0;
      for (int j = 0; j < BlockWidth; j++) begin
         r[BlockWidth-1-j] = v[BlockWidth-1-int'(TabIpInv[j])];
      end
      return r;
   endfunction

   function automatic subkey_type expand(half_type v);
      subkey_type r;
      r = '0;
      for (int j = 0; j < SubkeyWidth; j++) begin
         r[SubkeyWidth-1-j] = v[HalfWidth-1-int'(TabE[j])];
      end
      return r;
   endfunction

   function automatic half_type perm_p4(half_type v);
      half_type r;
      r = '0;
      for (int j = 0; j < HalfWidth; j++) begin
         r[HalfWidth-1-j] = v[HalfWidth-1-int'(TabP4[j])];
      end
      return r;
   endfunction

   // second subkey when late is set (rotate by 3), else first (rotate by 1)
   function automatic subkey_type make_subkey(key_type key, logic late);
      key_type    k;
      logic [4:0] hi;
      logic [4:0] lo;
      k  = perm_p10(key);
      hi = late ? {k[6:5], k[9:7]} : {k[8:5], k[9]};
      lo = late ? {k[1:0], k[4:2]} : {k[3:0], k[4]};
      return perm_p8({hi[2:0], lo});
   endfunction

   function automatic half_type round_f(half_type right, subkey_type k);
      subkey_type x;
      half_type   a;
      half_type   b;
      x = expand(right) ^ k;
      a = x[7:4];
      b = x[3:0];
      return perm_p4({TabS0[{a[3], a[0], a[2], a[1]}], TabS1[{b[3], b[0], b[2], b[1]}]});
   endfunction

endpackage

@@ sv/sdes_if.sv @@
`timescale 1ns / 1ps
// sdes_req_if and sdes_rsp_if: valid/ready channels for the cipher
// depends on sdes_pkg

interface sdes_req_if;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   sdes_pkg::block_type  block_in;

   modport source (output valid, output mode, output block_in, input ready);
   modport sink (input valid, input mode, input block_in, output ready);
endinterface

interface sdes_rsp_if;
   logic                 valid;
   logic                 ready;
   sdes_pkg::block_type  block_out;

   modport source (output valid, output block_out, input ready);
   modport sink (input valid, input block_out, output ready);
endinterface

@@ sv/sdes_block_cipher.sv @@
`timescale 1ns / 1ps
// sdes_block_cipher: simplified des, one byte per cycle while rsp_bus does not stall
// depends on sdes_pkg and sdes_if
//
//   channel   dir   handshake        payload
//   req_bus   in    valid / ready    mode, block_in
//   rsp_bus   out   valid / ready    block_out
//   csr_*     in    csr_write_en     csr_write_data (10-bit key)
//
// one request per cycle unless rsp_bus stalls; a taken request passes the input register, then the result register
// the input register feeds both rounds, the result register holds block_out
// a stalled result holds while the input register keeps one more request
// reset clears valid flags and the key to zero

module sdes_block_cipher (
   input  logic                  clock,
   input  logic                  reset,
   sdes_req_if.sink              req_bus,
   sdes_rsp_if.source            rsp_bus,
   input  logic                  csr_write_en,
   input  sdes_pkg::key_type     csr_write_data
);

   sdes_pkg::key_type     key_ff;
   logic                  in_valid_ff;
   logic                  in_mode_ff;
   sdes_pkg::block_type   in_block_ff;
   logic                  out_valid_ff;
   sdes_pkg::block_type   out_block_ff;

   logic                  out_free;
   logic                  in_free;
   sdes_pkg::subkey_type  k_first;
   sdes_pkg::subkey_type  k_second;
   sdes_pkg::block_type   ip_blk;
   sdes_pkg::half_type    l1;
   sdes_pkg::half_type    l2;
   sdes_pkg::block_type   out_block_in;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign in_free  = !in_valid_ff || out_free;
   assign req_bus.ready = in_free;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.block_out = out_block_ff;

   // decrypt swaps subkey order
   always_comb begin
      k_first  = sdes_pkg::make_subkey(key_ff, in_mode_ff);
      k_second = sdes_pkg::make_subkey(key_ff, !in_mode_ff);
      ip_blk   = sdes_pkg::perm_ip(in_block_ff);
      l1       = ip_blk[7:4] ^ sdes_pkg::round_f(ip_blk[3:0], k_first);
      l2       = ip_blk[3:0] ^ sdes_pkg::round_f(l1, k_second);
      out_block_in = sdes_pkg::perm_ip_inv({l2, l1});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            key_ff <= csr_write_data;
         end
         if (in_free) begin
            in_valid_ff <= req_bus.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_bus.valid) begin
         in_mode_ff  <= req_bus.mode;
         in_block_ff <= req_bus.block_in;
      end
      if (out_free && in_valid_ff) begin
         out_block_ff <= out_block_in;
      end
   end

   a_accept_fills_input: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> in_valid_ff)
      else $error("accepted request not held in input register");

   a_input_moves_to_output: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_free) |=> out_valid_ff)
      else $error("request lost between input and result register");

   a_input_holds_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_block_ff)
                                      && $stable(in_mode_ff)))
      else $error("input register changed while result stalled");

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("valid flags not cleared by reset");

endmodule
